// ===== src/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int POS_W  = 12;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 9;
	localparam int OP_W   = 3;
	localparam int GRP    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_GET    = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	// per-transaction control broadcast to every cell
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic                     rd;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== src/ple_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: shifts with its neighbors on insert and delete, and
// offers its entry to the read tree when selected.
// ----------------------------------------------------------------------------
module ple_cell
	import ple_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     adv,
	input  logic [POS_W-1:0]         idx,
	input  logic signed [DATA_W-1:0] from_lo,
	input  logic signed [DATA_W-1:0] from_hi,
	output logic signed [DATA_W-1:0] data,
	output logic signed [DATA_W-1:0] rd_s1
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		if (ctl.ins) begin
			if (idx > ctl.pos)
				data_d = from_lo;
			else if (idx == ctl.pos)
				data_d = ctl.value;
		end else if (ctl.del) begin
			if (idx >= ctl.pos)
				data_d = from_hi;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (adv)
			rd_s1 <= (ctl.rd && idx == ctl.pos) ? data_q : '0;
	end

	assign data = data_q;

endmodule

// ===== src/ple_rd_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_rd_tree
// Two-level registered OR tree that collects the selected cell's entry.
// ----------------------------------------------------------------------------
module ple_rd_tree
	import ple_pkg::*;
#(
	parameter int N = 256
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [DATA_W-1:0] leaf [N],
	output logic signed [DATA_W-1:0] rd_s3
);

	localparam int NG = (N + GRP - 1) / GRP;

	logic signed [DATA_W-1:0] grp_s2 [NG];
	logic signed [DATA_W-1:0] all_or;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic signed [DATA_W-1:0] grp_or;
		always_comb begin
			grp_or = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < N)
					grp_or = grp_or | leaf[g * GRP + j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv)
				grp_s2[g] <= grp_or;
		end
	end

	always_comb begin
		all_or = '0;
		for (int g = 0; g < NG; g++)
			all_or = all_or | grp_s2[g];
	end

	always_ff @(posedge clk) begin
		if (adv)
			rd_s3 <= all_or;
	end

endmodule

// ===== src/positional_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Results pass through registered stages s1, s2 and s3, held on an output stall.
// Throughput: one transaction per cycle unless stalled; higher cells shift on accept.
// The read path is a two-level registered OR tree over the cells.
// Reset clears the entry count and all valid flags; cell contents are
// left as they are and only read below the count.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OP_W-1:0]          op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     overflow
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic          adv, accept, full;
	logic          pos_le, pos_lt;
	logic [CW-1:0] count_q, count_d;
	logic          ovf_d, neg1_d;
	cell_ctl_t     ctl;

	logic v1_q, v2_q, v3_q;
	logic [CW-1:0] cnt_s1, cnt_s2, cnt_s3;
	logic ovf_s1, ovf_s2, ovf_s3;
	logic neg1_s1, neg1_s2, neg1_s3;

	logic signed [DATA_W-1:0] cdata [CAPACITY];
	logic signed [DATA_W-1:0] crd   [CAPACITY];
	logic signed [DATA_W-1:0] tree_rd;

	assign adv      = !(v3_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign full     = (count_q == CW'(CAPACITY));
	assign pos_le   = {1'b0, position} <= (POS_W + 1)'(count_q);
	assign pos_lt   = {1'b0, position} <  (POS_W + 1)'(count_q);

	always_comb begin
		count_d   = count_q;
		ovf_d     = 1'b0;
		neg1_d    = 1'b0;
		ctl.ins   = 1'b0;
		ctl.del   = 1'b0;
		ctl.rd    = 1'b0;
		ctl.pos   = position;
		ctl.value = value;
		case (op_t'(op))
			OP_APPEND: begin
				ctl.pos = POS_W'(count_q);
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					ctl.ins = accept;
					count_d = count_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (pos_le) begin
					if (full) begin
						ovf_d = 1'b1;
					end else begin
						ctl.ins = accept;
						count_d = count_q + 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (pos_lt) begin
					ctl.del = accept;
					count_d = count_q - 1'b1;
				end
			end
			OP_GET: begin
				ctl.rd = accept && pos_lt;
				neg1_d = !pos_lt;
			end
			OP_CLEAR: count_d = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
		end else begin
			if (accept)
				count_q <= count_d;
			if (adv) begin
				v1_q <= in_valid;
				v2_q <= v1_q;
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s1  <= count_d;
			ovf_s1  <= ovf_d;
			neg1_s1 <= neg1_d;
			cnt_s2  <= cnt_s1;
			ovf_s2  <= ovf_s1;
			neg1_s2 <= neg1_s1;
			cnt_s3  <= cnt_s2;
			ovf_s3  <= ovf_s2;
			neg1_s3 <= neg1_s2;
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [DATA_W-1:0] lo, hi;
		if (k > 0) begin : g_lo
			assign lo = cdata[k-1];
		end else begin : g_lo0
			assign lo = '0;
		end
		if (k < CAPACITY - 1) begin : g_hi
			assign hi = cdata[k+1];
		end else begin : g_hiN
			assign hi = '0;
		end
		ple_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.adv     (adv),
			.idx     (POS_W'(k)),
			.from_lo (lo),
			.from_hi (hi),
			.data    (cdata[k]),
			.rd_s1   (crd[k])
		);
	end

	ple_rd_tree #(.N(CAPACITY)) u_tree (
		.clk   (clk),
		.adv   (adv),
		.leaf  (crd),
		.rd_s3 (tree_rd)
	);

	assign out_valid   = v3_q;
	assign read_value  = tree_rd | {DATA_W{neg1_s3}};
	assign entry_count = CNT_W'(cnt_s3);
	assign overflow    = ovf_s3;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (cnt_s3 == CW'(CAPACITY)))
		else $error("overflow reported while list not full");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_t'(op) == OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the list");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(neg1_s3 && ovf_s3))
		else $error("get miss and overflow both flagged");
`endif

endmodule

// ===== tb/ple_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker
// Watches both channels of the positional list engine. It keeps a shadow
// copy of the list and works out the reply to each accepted command. Each
// reply is compared, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [OP_W-1:0]          op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] read_value,
	input  logic [CNT_W-1:0]         entry_count,
	input  logic                     overflow,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         entry_count;
		logic                     overflow;
	} list_reply_t;

	list_reply_t              predicted_replies[$];
	logic signed [DATA_W-1:0] shadow_list [CAPACITY];
	int unsigned              shadow_len;
	int                       errs = 0;

	function automatic list_reply_t apply_list_cmd(input logic [OP_W-1:0] cmd,
			input logic [POS_W-1:0] idx, input logic signed [DATA_W-1:0] val);
		list_reply_t r;
		int unsigned at;
		int k;
		r = '0;
		case (cmd)
			OP_APPEND, OP_INSERT: begin
				at = (cmd == OP_APPEND) ? shadow_len : idx;
				if (at <= shadow_len) begin
					if (shadow_len >= CAPACITY) begin
						r.overflow = 1'b1;
					end else begin
						for (k = shadow_len; k > at; k--)
							shadow_list[k] = shadow_list[k-1];
						shadow_list[at] = val;
						shadow_len++;
					end
				end
			end
			OP_DELETE: begin
				if (idx < shadow_len) begin
					for (k = idx; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k+1];
					shadow_len--;
				end
			end
			OP_GET: begin
				r.read_value = (idx < shadow_len) ? shadow_list[idx] : -32'sd1;
			end
			OP_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
			end
		endcase
		r.entry_count = shadow_len[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t got;
		list_reply_t want;
		if (!arst_n) begin
			shadow_len = 0;
			predicted_replies.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				predicted_replies.push_back(apply_list_cmd(op, position, value));
			if (out_valid && !out_stall) begin
				got = '{read_value, entry_count, overflow};
				if (predicted_replies.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("ple_checker: reply with none predicted: %0d %0d %0b",
							got.read_value, got.entry_count, got.overflow);
				end else begin
					want = predicted_replies.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10)
							$display({"ple_checker: mismatch: expected read_value %0d ",
								"entry_count %0d overflow %0b, got %0d %0d %0b"},
								want.read_value, want.entry_count, want.overflow,
								got.read_value, got.entry_count, got.overflow);
					end
				end
			end
			fail_count <= errs;
			pending <= predicted_replies.size();
		end
	end

endmodule

// ===== tb/positional_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives list commands into the engine: a directed pass over the edge cases,
// a fill to capacity, a long output hold-off, then random command mixes, some with
// bursty idling on both channels. The verdict comes from ple_checker.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int              CAPACITY     = 256;
	localparam int              HOLD_CYCLES  = 200;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          op = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         entry_count;
	logic                     overflow;
	int                       fail_count;
	int                       pending;

	bit idle_on = 1'b0;
	bit hold_req = 1'b0;
	int list_len = 0;

	positional_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .position(position), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .entry_count(entry_count), .overflow(overflow)
	);

	ple_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .position(position), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .entry_count(entry_count), .overflow(overflow),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// output side: random stall bursts, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_cmd(input logic [OP_W-1:0] cmd, input logic [POS_W-1:0] idx,
			input logic signed [DATA_W-1:0] val);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			op <= OP_W'($urandom);
			position <= POS_W'($urandom);
			value <= $urandom;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		position <= idx;
		value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		case (cmd)
			OP_APPEND: if (list_len < CAPACITY) list_len++;
			OP_INSERT: if (idx <= list_len && list_len < CAPACITY) list_len++;
			OP_DELETE: if (idx < list_len) list_len--;
			OP_CLEAR:  list_len = 0;
			default: begin
			end
		endcase
	endtask

	// grow_pct: share of appends and inserts; positions mostly in range
	task automatic run_random(input int n, input int grow_pct);
		int r;
		logic [OP_W-1:0] cmd;
		logic [POS_W-1:0] idx;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 199) == 0)
				cmd = OP_CLEAR;
			else if (r < 2)
				cmd = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			else if (r < 2 + grow_pct / 2)
				cmd = OP_APPEND;
			else if (r < 2 + grow_pct)
				cmd = OP_INSERT;
			else if ($urandom_range(0, 1) == 1)
				cmd = OP_DELETE;
			else
				cmd = OP_GET;
			r = $urandom_range(0, 19);
			if (r < 2)
				idx = POS_W'($urandom);
			else if (r == 2)
				idx = POS_W'(list_len);
			else if (cmd == OP_INSERT)
				idx = POS_W'($urandom_range(0, list_len));
			else
				idx = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
			send_cmd(cmd, idx, $urandom);
		end
	endtask

	initial begin
		int i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// empty list, extremes, insert at end, out-of-range cases
		send_cmd(OP_GET, '0, '0);
		send_cmd(OP_DELETE, '0, '0);
		send_cmd(OP_INSERT, 12'd1, '0);
		send_cmd(OP_INSERT, '0, 32'h8000_0000);
		send_cmd(OP_APPEND, '0, 32'h7fff_ffff);
		send_cmd(OP_APPEND, 12'hfff, -32'sd1);
		send_cmd(OP_INSERT, 12'd1, '0);
		send_cmd(OP_INSERT, 12'd4, 32'h5a5a_a5a5);
		for (i = 0; i < 5; i++)
			send_cmd(OP_GET, POS_W'(i), '0);
		send_cmd(OP_GET, 12'hfff, '0);
		send_cmd(OP_DELETE, '0, '0);
		send_cmd(OP_DELETE, POS_W'(list_len - 1), '0);
		send_cmd(OP_DELETE, 12'hfff, '0);
		for (i = OP_UNUSED_LO; i <= OP_UNUSED_HI; i++)
			send_cmd(OP_W'(i), POS_W'($urandom), $urandom);
		send_cmd(OP_CLEAR, POS_W'($urandom), $urandom);
		send_cmd(OP_GET, '0, '0);

		// full list
		while (list_len < CAPACITY)
			send_cmd(OP_APPEND, POS_W'($urandom), $urandom);
		send_cmd(OP_APPEND, '0, $urandom);
		send_cmd(OP_INSERT, '0, $urandom);
		send_cmd(OP_INSERT, POS_W'(CAPACITY), $urandom);
		send_cmd(OP_INSERT, POS_W'(CAPACITY + 1), $urandom);
		send_cmd(OP_GET, POS_W'(CAPACITY - 1), '0);
		send_cmd(OP_GET, POS_W'(CAPACITY), '0);
		send_cmd(OP_DELETE, POS_W'(CAPACITY - 1), '0);
		send_cmd(OP_INSERT, 12'd7, $urandom);

		// backpressure: receiver holds off while commands keep coming
		idle_on = 1'b0;
		hold_req = 1'b1;
		run_random(40, 50);

		idle_on = 1'b1;
		run_random(100, 80);
		idle_on = 1'b0;
		run_random(60, 50);
		idle_on = 1'b1;
		run_random(100, 75);
		run_random(100, 25);
		run_random(60, 60);
		idle_on = 1'b0;
		run_random(60, 50);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
